@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define CHK_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while rst is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ src/stv_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stv_pkg
// Types, codes and constants of the stepper travel sequencer.
// ---------------------------------------------------------------------------
package stv_pkg;

   localparam int unsigned POSITION_WIDTH_DEF = 12;
   localparam int unsigned LIMIT_W            = 12;
   localparam int unsigned THRESH_W           = 8;
   localparam int unsigned CSR_DATA_W         = 12;

   localparam logic [LIMIT_W-1:0]  TRAVEL_LIMIT_RST    = 12'd1000;
   localparam logic [THRESH_W-1:0] BLINK_THRESHOLD_RST = 8'd50;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_BUTTON = 2'd1,
      OP_SENSOR = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic {
      CSR_TRAVEL_LIMIT    = 1'b0,
      CSR_BLINK_THRESHOLD = 1'b1
   } csr_index_type;

   // LED bit order, MSB first: green, blue, red
   typedef struct packed {
      logic green;
      logic blue;
      logic red;
   } led_type;

   localparam led_type LED_GREEN_ONLY = '{green: 1'b1, blue: 1'b0, red: 1'b0};
   localparam led_type LED_BLUE_ONLY  = '{green: 1'b0, blue: 1'b1, red: 1'b0};

   localparam logic [3:0] COIL_PH0 = 4'd12;
   localparam logic [3:0] COIL_PH1 = 4'd6;
   localparam logic [3:0] COIL_PH2 = 4'd3;
   localparam logic [3:0] COIL_PH3 = 4'd9;

   typedef struct packed {
      logic [1:0] opcode;
      logic       sensor_level;
   } req_type;

   typedef struct packed {
      logic [3:0]         coil_pattern;
      logic               led_red;
      logic               led_blue;
      logic               led_green;
      logic [LIMIT_W-1:0] position;
   } rsp_type;

   function automatic logic [3:0] coil_of(input logic [1:0] ph);
      logic [3:0] c;
      unique case (ph)
         2'd0: c = COIL_PH0;
         2'd1: c = COIL_PH1;
         2'd2: c = COIL_PH2;
         2'd3: c = COIL_PH3;
         default: c = COIL_PH0;
      endcase
      return c;
   endfunction

endpackage

@@ src/stepper_travel_sequencer.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stepper_travel_sequencer
// Full-step stepper sequencer with travel limits and indicator LEDs.
// ---------------------------------------------------------------------------
// Takes one event beat per cycle while rsp_ready is high (tick, button press,
// sensor edge) and returns one result beat per event, carrying the coil drive,
// the three LED bits and the step position as they stand after that event. An
// event is held in the request register, then one pass of logic updates the
// motor state and loads the response register; a stalled response can hold it
// there. The state takes a single update per cycle. The request register
// refills while a response waits to be taken; backpressure reaches req_ready
// only when both registers hold a beat. Write travel_limit and blink_threshold
// while no event is in flight.
module stepper_travel_sequencer #(
   parameter int unsigned POSITION_WIDTH = stv_pkg::POSITION_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  stv_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output stv_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [stv_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import stv_pkg::*;

   // comparison width covers both the limit register and the position
   localparam int unsigned CMP_W = (POSITION_WIDTH > LIMIT_W) ? POSITION_WIDTH : LIMIT_W;

   // configuration registers
   logic [LIMIT_W-1:0]  travel_limit_ff;
   logic [THRESH_W-1:0] blink_threshold_ff;

   // request stage
   logic    in_valid_ff;
   req_type in_data_ff;

   // motor and indicator state
   logic [1:0]                phase_ff,    phase_in;
   logic [POSITION_WIDTH-1:0] position_ff, position_in;
   logic                      extend_ff,   extend_in;
   logic [THRESH_W-1:0]       blink_ff,    blink_in;
   led_type                   led_ff,      led_in;

   // response stage
   logic    out_valid_ff;
   rsp_type out_data_ff, out_data_in;

   logic advance;       // request beat moves into the response register
   logic out_free;
   logic [CMP_W-1:0] lim_ext, mask_ext, eff_lim, pos_ext;
   logic [THRESH_W-1:0] blink_inc;
   logic [CMP_W-1:0] pos_next_ext;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Config writes: index selects one of the two registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         travel_limit_ff    <= TRAVEL_LIMIT_RST;
         blink_threshold_ff <= BLINK_THRESHOLD_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TRAVEL_LIMIT:    travel_limit_ff    <= csr_wdata[LIMIT_W-1:0];
            CSR_BLINK_THRESHOLD: blink_threshold_ff <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective limit: the smaller of the register and the largest position.
   assign lim_ext  = CMP_W'(travel_limit_ff);
   assign mask_ext = CMP_W'({POSITION_WIDTH{1'b1}});
   assign eff_lim  = (lim_ext > mask_ext) ? mask_ext : lim_ext;
   assign pos_ext  = CMP_W'(position_ff);
   assign blink_inc = blink_ff + THRESH_W'(1);

   // Next state for the event in the request register.
   always_comb begin
      phase_in    = phase_ff;
      position_in = position_ff;
      extend_in   = extend_ff;
      blink_in    = blink_ff;
      led_in      = led_ff;
      unique case (opcode_type'(in_data_ff.opcode))
         OP_TICK: begin
            // advance the blink counter, toggle red past the threshold
            blink_in = blink_inc;
            if (blink_inc > blink_threshold_ff) begin
               led_in   = '{green: 1'b0, blue: 1'b0, red: !led_ff.red};
               blink_in = '0;
            end
            // step one phase; at either end show the end color instead
            if (extend_ff) begin
               if (pos_ext < eff_lim) begin
                  phase_in    = phase_ff + 2'd1;
                  position_in = position_ff + POSITION_WIDTH'(1);
               end else begin
                  led_in = LED_BLUE_ONLY;
               end
            end else begin
               if (position_ff != '0) begin
                  phase_in    = phase_ff - 2'd1;
                  position_in = position_ff - POSITION_WIDTH'(1);
               end else begin
                  led_in = LED_GREEN_ONLY;
               end
            end
         end
         OP_BUTTON: extend_in = !extend_ff;
         OP_SENSOR: begin
            blink_in  = '0;
            extend_in = !in_data_ff.sensor_level;
         end
         OP_NONE: ;
         default: ;
      endcase
   end

   assign pos_next_ext = CMP_W'(position_in);

   always_comb begin
      out_data_in.coil_pattern = coil_of(phase_in);
      out_data_in.led_red      = led_in.red;
      out_data_in.led_blue     = led_in.blue;
      out_data_in.led_green    = led_in.green;
      out_data_in.position     = pos_next_ext[LIMIT_W-1:0];
   end

   // Request register: load on accept, drop when the beat advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // State and response register update together when a beat advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         position_ff  <= '0;
         extend_ff    <= 1'b0;
         blink_ff     <= '0;
         led_ff       <= LED_GREEN_ONLY;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff     <= phase_in;
            position_ff  <= position_in;
            extend_ff    <= extend_in;
            blink_ff     <= blink_in;
            led_ff       <= led_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

@@ src/stv_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stv_checker
// Port-level checks for the stepper travel sequencer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stv_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input stv_pkg::rsp_type rsp_data
);
   import stv_pkg::*;

   logic req_fire;
   logic coil_ok;

   assign req_fire = req_valid && req_ready;
   assign coil_ok  = (rsp_data.coil_pattern == COIL_PH0) ||
                     (rsp_data.coil_pattern == COIL_PH1) ||
                     (rsp_data.coil_pattern == COIL_PH2) ||
                     (rsp_data.coil_pattern == COIL_PH3);

   // a stalled response beat holds
   `CHK_NEXT(rsp_hold_a, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // no response right after reset
   `CHK_NEXT(rsp_reset_a, clock, 1'b0, reset, !rsp_valid)
   // a new response follows an accepted request beat through the request and response registers
   `CHK_SAME(rsp_src_a, clock, reset, $rose(rsp_valid), $past(req_fire, 2))
   // coil drive is always one of the four full-step patterns
   `CHK_SAME(rsp_coil_a, clock, reset, rsp_valid, coil_ok)
   // at most one indicator lit
   `CHK_SAME(rsp_led_a, clock, reset, rsp_valid,
             $onehot0({rsp_data.led_red, rsp_data.led_blue, rsp_data.led_green}))

endmodule

bind stepper_travel_sequencer stv_checker u_stv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ verif/tb_stepper_travel_sequencer.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_stepper_travel_sequencer
// Self-checking testbench for the stepper travel sequencer.
// ---------------------------------------------------------------------------
// Send a directed run of event beats that covers the travel ends, the blink
// threshold extremes and a limit lowered below the current position. Then
// send phases of random events under several register settings. A scoreboard
// tracks the motor state on its own and predicts one result per accepted
// event. Results are checked in order, field by field. Both channels idle at
// random, and one phase stalls the result side long enough to back up the
// request side.
module tb_stepper_travel_sequencer;
   import stv_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned HOLD_OFF_CYCLES = 80;
   localparam int unsigned QUIET_LIMIT = 1000;

   // ------------------------------------------------------------------------
   // Scoreboard: own copy of the motor state and the two registers
   // ------------------------------------------------------------------------
   class travel_scoreboard;
      logic [LIMIT_W-1:0]  travel_limit;
      logic [THRESH_W-1:0] blink_threshold;
      logic [1:0]          phase;
      logic [LIMIT_W-1:0]  position;
      bit                  extending;
      logic [7:0]          blink_count;
      led_type             leds;
      logic [3:0]          coil_by_phase [4];
      rsp_type             expected_moves [$];
      int unsigned         mismatches;

      function new();
         travel_limit     = TRAVEL_LIMIT_RST;
         blink_threshold  = BLINK_THRESHOLD_RST;
         phase            = 2'd0;
         position         = '0;
         extending        = 1'b0;
         blink_count      = 8'd0;
         leds             = LED_GREEN_ONLY;
         coil_by_phase[0] = COIL_PH0;
         coil_by_phase[1] = COIL_PH1;
         coil_by_phase[2] = COIL_PH2;
         coil_by_phase[3] = COIL_PH3;
         mismatches       = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_TRAVEL_LIMIT)
            travel_limit = value[LIMIT_W-1:0];
         else
            blink_threshold = value[THRESH_W-1:0];
      endfunction

      // One tick: blink first, then step; an end color wins over the blink.
      function void advance_motor();
         blink_count = blink_count + 8'd1;
         if (blink_count > blink_threshold) begin
            leds = '{green: 1'b0, blue: 1'b0, red: ~leds.red};
            blink_count = 8'd0;
         end
         if (extending) begin
            if (position < travel_limit) begin
               phase = phase + 2'd1;
               position = position + LIMIT_W'(1);
            end else begin
               leds = LED_BLUE_ONLY;
            end
         end else begin
            if (position != '0) begin
               phase = phase - 2'd1;
               position = position - LIMIT_W'(1);
            end else begin
               leds = LED_GREEN_ONLY;
            end
         end
      endfunction

      function void note_event(req_type ev);
         rsp_type want;
         case (opcode_type'(ev.opcode))
            OP_TICK: advance_motor();
            OP_BUTTON: extending = ~extending;
            OP_SENSOR: begin
               blink_count = 8'd0;
               extending = ~ev.sensor_level;
            end
            default: begin
            end
         endcase
         want.coil_pattern = coil_by_phase[phase];
         want.led_red      = leds.red;
         want.led_blue     = leds.blue;
         want.led_green    = leds.green;
         want.position     = position;
         expected_moves.push_back(want);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_moves.size() == 0) begin
            $error("result beat with nothing expected: %h", got);
            mismatches++;
            return;
         end
         want = expected_moves.pop_front();
         if (got.coil_pattern !== want.coil_pattern) begin
            $error("coil_pattern: expected %0d, got %0d", want.coil_pattern, got.coil_pattern);
            mismatches++;
         end
         if (got.led_red !== want.led_red) begin
            $error("led_red: expected %0b, got %0b", want.led_red, got.led_red);
            mismatches++;
         end
         if (got.led_blue !== want.led_blue) begin
            $error("led_blue: expected %0b, got %0b", want.led_blue, got.led_blue);
            mismatches++;
         end
         if (got.led_green !== want.led_green) begin
            $error("led_green: expected %0b, got %0b", want.led_green, got.led_green);
            mismatches++;
         end
         if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return expected_moves.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Block under test
   // ------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   travel_scoreboard sb;
   bit               sender_idle_on;
   bit               receiver_idle_on;
   bit               hold_off_request;

   stepper_travel_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   // Offer one event beat; hold valid and payload until the beat is taken.
   task automatic offer_event(input req_type ev);
      int unsigned gap;
      gap = sender_idle_on ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (!req_ready);
      sb.note_event(ev);
   endtask

   task automatic offer_op(input opcode_type op, input logic level);
      req_type ev;
      ev.opcode = op;
      ev.sensor_level = level;
      offer_event(ev);
   endtask

   // Mostly ticks so the travel ends and the blink threshold get reached;
   // button presses and sensor edges reverse the motor now and then.
   function automatic req_type draw_event(input int unsigned tick_pct,
                                          input int unsigned button_pct,
                                          input int unsigned sensor_pct);
      req_type     ev;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < tick_pct)
         ev.opcode = OP_TICK;
      else if (roll < tick_pct + button_pct)
         ev.opcode = OP_BUTTON;
      else if (roll < tick_pct + button_pct + sensor_pct)
         ev.opcode = OP_SENSOR;
      else
         ev.opcode = OP_NONE;
      ev.sensor_level = 1'($urandom_range(0, 1));
      return ev;
   endfunction

   // Drop valid, drain every expected result, let the pipe settle, then write.
   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_register(idx, value);
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] limit,
                            input logic [CSR_DATA_W-1:0] threshold,
                            input int unsigned count,
                            input int unsigned tick_pct,
                            input int unsigned button_pct,
                            input int unsigned sensor_pct,
                            input bit sender_idle,
                            input bit receiver_idle,
                            input bit hold_off);
      write_register(CSR_TRAVEL_LIMIT, limit);
      write_register(CSR_BLINK_THRESHOLD, threshold);
      sender_idle_on   = sender_idle;
      receiver_idle_on = receiver_idle;
      hold_off_request = hold_off;
      repeat (count) offer_event(draw_event(tick_pct, button_pct, sensor_pct));
   endtask

   // ------------------------------------------------------------------------
   // Receiver side: draw a wait per beat, or hold off long on request
   // ------------------------------------------------------------------------
   task automatic serve_results();
      int unsigned gap;
      forever begin
         gap = receiver_idle_on ? $urandom_range(0, 11) : 0;
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            gap = HOLD_OFF_CYCLES;
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_data);
      end
   endtask

   // ------------------------------------------------------------------------
   // Watchdog: end the run when no beat and no write moves for too long
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      sb = new();
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
      hold_off_request = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_ready <= 1'b0;
      csr_we    <= 1'b0;
      csr_index <= CSR_TRAVEL_LIMIT;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      fork
         serve_results();
      join_none

      // Reset settings: unused opcode, home end, one step out and back.
      offer_op(OP_NONE, 1'b1);
      offer_op(OP_TICK, 1'b0);      // retracting at zero: green only
      offer_op(OP_BUTTON, 1'b1);    // level ignored, toggle to extend
      offer_op(OP_TICK, 1'b1);
      offer_op(OP_SENSOR, 1'b1);    // retract
      offer_op(OP_TICK, 1'b0);
      offer_op(OP_TICK, 1'b0);
      offer_op(OP_SENSOR, 1'b0);    // extend
      offer_op(OP_NONE, 1'b0);

      // Tiny travel, zero threshold: red flips on every tick until the
      // outer end forces blue only.
      write_register(CSR_TRAVEL_LIMIT, 12'd3);
      write_register(CSR_BLINK_THRESHOLD, 12'd0);
      repeat (5) offer_op(OP_TICK, 1'b0);

      // Lower the limit below the current position: no outward step,
      // inward steps still run down to home.
      write_register(CSR_TRAVEL_LIMIT, 12'd1);
      offer_op(OP_TICK, 1'b1);
      offer_op(OP_SENSOR, 1'b1);
      repeat (4) offer_op(OP_TICK, 1'b0);

      // Zero limit, highest threshold: both ends at position zero.
      write_register(CSR_TRAVEL_LIMIT, 12'd0);
      write_register(CSR_BLINK_THRESHOLD, 12'd255);
      offer_op(OP_SENSOR, 1'b0);
      offer_op(OP_TICK, 1'b1);
      offer_op(OP_BUTTON, 1'b0);
      offer_op(OP_TICK, 1'b0);

      // Random phases: limit, threshold, beats, tick/button/sensor percent,
      // sender idles, receiver idles, long receiver hold-off.
      run_phase(12'd1000, 12'd50, 150, 70, 10, 10, 1'b1, 1'b1, 1'b0);
      run_phase(12'd0, 12'd0, 100, 50, 20, 20, 1'b1, 1'b1, 1'b0);
      // Full-rate sender against a stalled receiver: fill the block.
      run_phase(12'd7, 12'd3, 250, 70, 10, 15, 1'b0, 1'b0, 1'b1);
      // Long tick runs so the 8-bit count wraps past the top threshold.
      run_phase(12'd4095, 12'd255, 350, 95, 3, 0, 1'b1, 1'b0, 1'b0);
      run_phase(12'd15, 12'd1, 200, 65, 10, 15, 1'b1, 1'b1, 1'b0);
      run_phase(12'd2048, 12'd128, 200, 80, 5, 10, 1'b0, 1'b1, 1'b0);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES + 2) @(posedge clock);

      if (sb.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
